// ===== hw/rtl/fkirt_pkg.sv =====
`timescale 1ns / 1ps

package fkirt_pkg;

  // Table geometry.
  localparam int unsigned DEPTH  = 4096;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned NPORTS = 4;

  // Replayed words always have bit 4 cleared.
  localparam logic [31:0] DROP_MASK = 32'hFFFF_FFEF;

  // Action codes of an input item.
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Status codes of a result item.
  localparam logic [2:0] ST_APPENDED = 3'd0;
  localparam logic [2:0] ST_MERGED   = 3'd1;
  localparam logic [2:0] ST_BADPORT  = 3'd2;
  localparam logic [2:0] ST_OLDER    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_FOUND    = 3'd5;
  localparam logic [2:0] ST_NOTFOUND = 3'd6;
  localparam logic [2:0] ST_CLEARED  = 3'd7;

  // One row of the port word memory: present bits and the four port words.
  typedef struct packed {
    logic [NPORTS-1:0]       present;
    logic [NPORTS-1:0][31:0] words;
  } row_t;

endpackage

// ===== hw/rtl/frame_keyed_input_replay_table_top.sv =====
`timescale 1ns / 1ps

// Load, clear and unused actions: the result passes from S_EXEC through S_EMIT into the
// output register before the next item is taken. Query: a last-hit match goes through
// S_FAST_CMP, S_ROW_RD and S_ROW; else a binary search on the key memory, one S_PROBE
// and S_CMP per probe (up to 13 probes at 4096 entries). One item is worked on at a time.
// Reset (rst_ni low, asynchronous) empties the table and turns playback off; the memories
// are not cleared, and no entry is read before it is written.
module frame_keyed_input_replay_table_top
  import fkirt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] port_i,
  input  logic [63:0]        frame_i,
  input  logic [31:0]        pad_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [31:0]        port0_value_o,
  output logic [31:0]        port1_value_o,
  output logic [31:0]        port2_value_o,
  output logic [31:0]        port3_value_o,
  output logic [2:0]         present_count_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FAST_CMP,
    S_PROBE,
    S_CMP,
    S_ROW_RD,
    S_ROW,
    S_EMIT
  } state_e;

  // Memories: frame keys and rows of port words with present bits.
  logic [63:0] key_mem [DEPTH];
  row_t        row_mem [DEPTH];
  logic [63:0] key_rdata_q;
  row_t        row_rdata_q;

  state_e                  state_q;
  logic                    playback_q;
  logic [CNT_W-1:0]        count_q;
  logic [IDX_W-1:0]        last_hit_q;
  logic [63:0]             last_key_q;
  row_t                    last_row_q;

  // Accepted item.
  logic [1:0]              action_q;
  logic                    port_ok_q;
  logic [1:0]              port_sel_q;
  logic [63:0]             frame_q;
  logic [31:0]             pad_q;

  // Search state.
  logic [CNT_W-1:0]        lo_q;
  logic [CNT_W-1:0]        hi_q;
  logic [CNT_W-1:0]        mid_q;
  logic                    hit_q;
  logic [IDX_W-1:0]        idx_q;

  // Pending result and output register.
  logic [2:0]              res_status_q;
  logic [NPORTS-1:0][31:0] res_words_q;
  logic [2:0]              res_count_q;
  logic                    out_valid_q;
  logic [2:0]              out_status_q;
  logic [NPORTS-1:0][31:0] out_words_q;
  logic [2:0]              out_count_q;

  // Combinational helpers.
  logic [CNT_W-1:0]        mid;
  logic [CNT_W-1:0]        count_m1;
  logic [IDX_W-1:0]        key_raddr;
  logic [IDX_W-1:0]        row_raddr;
  logic [IDX_W-1:0]        wr_addr;
  row_t                    row_new;
  row_t                    row_merge;
  row_t                    wr_row;
  logic                    is_newer;
  logic                    is_full;
  logic                    append_en;
  logic                    merge_en;
  logic                    do_load;
  logic                    key_we;
  logic                    row_we;
  logic [2:0]              load_status;
  logic [2:0]              row_count;

  // Search midpoint, read addresses and load decisions.
  always_comb begin
    mid       = lo_q + ((hi_q - lo_q) >> 1);
    count_m1  = count_q - CNT_W'(1);
    key_raddr = (state_q == S_PROBE) ? mid[IDX_W-1:0] : last_hit_q;
    row_raddr = idx_q;

    row_new                     = '0;
    row_new.words[port_sel_q]   = pad_q;
    row_new.present[port_sel_q] = 1'b1;
    row_merge                     = last_row_q;
    row_merge.words[port_sel_q]   = pad_q;
    row_merge.present[port_sel_q] = 1'b1;

    is_newer  = (count_q == '0) || (frame_q > last_key_q);
    is_full   = (count_q == CNT_W'(DEPTH));
    append_en = 1'b0;
    merge_en  = 1'b0;
    if (!port_ok_q) begin
      load_status = ST_BADPORT;
    end else if (is_newer) begin
      if (is_full) begin
        load_status = ST_FULL;
      end else begin
        load_status = ST_APPENDED;
        append_en   = 1'b1;
      end
    end else if (frame_q < last_key_q) begin
      load_status = ST_OLDER;
    end else begin
      load_status = ST_MERGED;
      merge_en    = 1'b1;
    end

    do_load = (state_q == S_EXEC) && (action_q == ACT_LOAD);
    key_we  = do_load && append_en;
    row_we  = do_load && (append_en || merge_en);
    wr_addr = append_en ? count_q[IDX_W-1:0] : count_m1[IDX_W-1:0];
    wr_row  = append_en ? row_new : row_merge;

    row_count = {2'b0, row_rdata_q.present[0]} + {2'b0, row_rdata_q.present[1]}
              + {2'b0, row_rdata_q.present[2]} + {2'b0, row_rdata_q.present[3]};
  end

  // Key memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= frame_q;
    end
    key_rdata_q <= key_mem[key_raddr];
  end

  // Row memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[wr_addr] <= wr_row;
    end
    row_rdata_q <= row_mem[row_raddr];
  end

  // Sequencer, table bookkeeping and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      playback_q   <= 1'b0;
      count_q      <= '0;
      last_hit_q   <= '0;
      last_key_q   <= '0;
      last_row_q   <= '0;
      action_q     <= ACT_LOAD;
      port_ok_q    <= 1'b0;
      port_sel_q   <= '0;
      frame_q      <= '0;
      pad_q        <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      mid_q        <= '0;
      hit_q        <= 1'b0;
      idx_q        <= '0;
      res_status_q <= ST_NOTFOUND;
      res_words_q  <= '0;
      res_count_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_NOTFOUND;
      out_words_q  <= '0;
      out_count_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        playback_q <= cfg_wdata_i;
      end

      // The output register empties on a transfer out; in S_EMIT it is refilled instead.
      if (out_valid_q && !out_stall_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            action_q   <= action_i;
            port_ok_q  <= (port_i[31:2] == '0);
            port_sel_q <= port_i[1:0];
            frame_q    <= frame_i;
            pad_q      <= pad_value_i;
            state_q    <= S_EXEC;
          end
        end

        S_EXEC: begin
          res_words_q <= '0;
          res_count_q <= '0;
          case (action_q)
            ACT_LOAD: begin
              res_status_q <= load_status;
              if (append_en) begin
                count_q    <= count_q + CNT_W'(1);
                last_key_q <= frame_q;
                last_row_q <= row_new;
              end else if (merge_en) begin
                last_row_q <= row_merge;
              end
              state_q <= S_EMIT;
            end
            ACT_QUERY: begin
              if (!playback_q || count_q == '0) begin
                res_status_q <= ST_NOTFOUND;
                state_q      <= S_EMIT;
              end else if ({1'b0, last_hit_q} < count_q) begin
                state_q <= S_FAST_CMP;
              end else begin
                lo_q    <= '0;
                hi_q    <= count_q;
                hit_q   <= 1'b0;
                state_q <= S_PROBE;
              end
            end
            ACT_CLEAR: begin
              count_q      <= '0;
              last_hit_q   <= '0;
              res_status_q <= ST_CLEARED;
              state_q      <= S_EMIT;
            end
            default: begin
              res_status_q <= ST_NOTFOUND;
              state_q      <= S_EMIT;
            end
          endcase
        end

        // Fast path: the key at the last hit was read in the previous cycle.
        S_FAST_CMP: begin
          if (key_rdata_q == frame_q) begin
            idx_q   <= last_hit_q;
            state_q <= S_ROW_RD;
          end else begin
            lo_q    <= '0;
            hi_q    <= count_q;
            hit_q   <= 1'b0;
            state_q <= S_PROBE;
          end
        end

        // Issue the read at the midpoint, or finish the search.
        S_PROBE: begin
          if (lo_q < hi_q) begin
            mid_q   <= mid;
            state_q <= S_CMP;
          end else if (hit_q) begin
            state_q <= S_ROW_RD;
          end else begin
            res_status_q <= ST_NOTFOUND;
            state_q      <= S_EMIT;
          end
        end

        // Narrow the range; keys are strictly increasing, so an equal key is the answer.
        S_CMP: begin
          if (key_rdata_q < frame_q) begin
            lo_q <= mid_q + CNT_W'(1);
          end else begin
            hi_q <= mid_q;
          end
          if (key_rdata_q == frame_q) begin
            hit_q <= 1'b1;
            idx_q <= mid_q[IDX_W-1:0];
          end
          state_q <= S_PROBE;
        end

        S_ROW_RD: begin
          last_hit_q <= idx_q;
          state_q    <= S_ROW;
        end

        // Build the found result from the row.
        S_ROW: begin
          for (int i = 0; i < NPORTS; i++) begin
            res_words_q[i] <= row_rdata_q.present[i] ? (row_rdata_q.words[i] & DROP_MASK)
                                                     : 32'd0;
          end
          res_count_q  <= row_count;
          res_status_q <= ST_FOUND;
          state_q      <= S_EMIT;
        end

        // Hand the result to the output register once it is free.
        S_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_words_q  <= res_words_q;
            out_count_q  <= res_count_q;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign port0_value_o   = out_words_q[0];
  assign port1_value_o   = out_words_q[1];
  assign port2_value_o   = out_words_q[2];
  assign port3_value_o   = out_words_q[3];
  assign present_count_o = out_count_q;

endmodule

// ===== tb/tb_frame_keyed_input_replay_table_top.sv =====
`timescale 1ns / 1ps

module tb_frame_keyed_input_replay_table_top;
  import fkirt_pkg::*;

  // The fourth action code is not decoded by the block.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // One result as the block reports it; words[0] belongs to port 0.
  typedef struct packed {
    logic [2:0]              status;
    logic [NPORTS-1:0][31:0] words;
    logic [2:0]              count;
  } reply_t;

  // One row of the directed table: a register write or an input transfer.
  typedef struct {
    logic        cfg_row;
    logic        cfg_val;
    logic [1:0]  action;
    logic [31:0] port;
    logic [63:0] frame;
    logic [31:0] pad;
    logic        typed;
    reply_t      reply;
  } step_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         action_i;
  logic [31:0]        port_i;
  logic [63:0]        frame_i;
  logic [31:0]        pad_value_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic [31:0]        port0_value_o;
  logic [31:0]        port1_value_o;
  logic [31:0]        port2_value_o;
  logic [31:0]        port3_value_o;
  logic [2:0]         present_count_o;

  // Shadow copy of the replay table and the playback register.
  logic [63:0]             key_mem [DEPTH];
  logic [NPORTS-1:0][31:0] word_mem [DEPTH];
  logic [NPORTS-1:0]       present_mem [DEPTH];
  int unsigned             entry_cnt;
  int unsigned             hit_idx;
  logic                    playback;

  reply_t      pending_replies[$];
  step_t       directed_steps[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned transfers_in;
  int unsigned replies_seen;
  int unsigned found_seen;
  int unsigned full_seen;

  frame_keyed_input_replay_table_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .port_i         (port_i),
    .frame_i        (frame_i),
    .pad_value_i    (pad_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .port0_value_o  (port0_value_o),
    .port1_value_o  (port1_value_o),
    .port2_value_o  (port2_value_o),
    .port3_value_o  (port3_value_o),
    .present_count_o(present_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Applies one transfer to the shadow table and returns the reply it must produce.
  function automatic reply_t predict_reply(logic [1:0] act, logic [31:0] port,
                                           logic [63:0] frame, logic [31:0] pad);
    reply_t           r;
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      mid;
    int unsigned      idx;
    int               i;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] top;
    r    = '0;
    slot = IDX_W'(entry_cnt);
    top  = IDX_W'(entry_cnt - 1);
    case (act)
      ACT_LOAD: begin
        if (port > 32'd3) begin
          r.status = ST_BADPORT;
        end else if (entry_cnt == 0 || frame > key_mem[top]) begin
          if (entry_cnt >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            // A new frame starts from an empty entry.
            key_mem[slot]                 = frame;
            word_mem[slot]                = '0;
            present_mem[slot]             = '0;
            word_mem[slot][port[1:0]]     = pad;
            present_mem[slot][port[1:0]]  = 1'b1;
            entry_cnt                     = entry_cnt + 1;
            r.status                      = ST_APPENDED;
          end
        end else if (frame < key_mem[top]) begin
          r.status = ST_OLDER;
        end else begin
          word_mem[top][port[1:0]]    = pad;
          present_mem[top][port[1:0]] = 1'b1;
          r.status                    = ST_MERGED;
        end
      end
      ACT_QUERY: begin
        r.status = ST_NOTFOUND;
        if (playback && entry_cnt != 0) begin
          idx = hit_idx;
          // The last hit is tried first, then a lower-bound search over the keys.
          if (!(idx < entry_cnt && key_mem[IDX_W'(idx)] == frame)) begin
            lo = 0;
            hi = entry_cnt;
            while (lo < hi) begin
              mid = lo + (hi - lo) / 2;
              if (key_mem[IDX_W'(mid)] < frame) lo = mid + 1;
              else hi = mid;
            end
            idx = lo;
          end
          if (idx < entry_cnt && key_mem[IDX_W'(idx)] == frame) begin
            hit_idx  = idx;
            r.status = ST_FOUND;
            for (i = 0; i < NPORTS; i++) begin
              if (present_mem[IDX_W'(idx)][i]) begin
                r.words[i] = word_mem[IDX_W'(idx)][i] & DROP_MASK;
                r.count    = r.count + 3'd1;
              end
            end
          end
        end
      end
      ACT_CLEAR: begin
        entry_cnt = 0;
        hit_idx   = 0;
        r.status  = ST_CLEARED;
      end
      default: r.status = ST_NOTFOUND;
    endcase
    return r;
  endfunction

  function automatic reply_t status_reply(logic [2:0] st);
    reply_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  // Presents one transfer, waits for it to be taken and records its expected reply.
  task automatic send_item(input logic [1:0] act, input logic [31:0] port,
                           input logic [63:0] frame, input logic [31:0] pad,
                           input logic typed, input reply_t fixed);
    reply_t pred;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    port_i      <= port;
    frame_i     <= frame;
    pad_value_i <= pad;
    do @(posedge clk_i); while (in_stall_o);
    pred = predict_reply(act, port, frame, pad);
    pending_replies.push_back(typed ? fixed : pred);
    transfers_in++;
  endtask

  // Drops valid and lets every outstanding reply drain.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_playback(input logic val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    playback     = val;
  endtask

  task automatic add_row(input logic [1:0] act, input logic [31:0] port,
                         input logic [63:0] frame, input logic [31:0] pad,
                         input logic typed, input reply_t reply);
    step_t s;
    s.cfg_row = 1'b0;
    s.cfg_val = 1'b0;
    s.action  = act;
    s.port    = port;
    s.frame   = frame;
    s.pad     = pad;
    s.typed   = typed;
    s.reply   = reply;
    directed_steps.push_back(s);
  endtask

  task automatic add_cfg(input logic val);
    step_t s;
    s         = '{default: '0};
    s.cfg_row = 1'b1;
    s.cfg_val = val;
    directed_steps.push_back(s);
  endtask

  // Mostly well-formed recording and playback, with bad ports, stale frames and noise.
  task automatic random_item();
    int unsigned r;
    logic [63:0] last_key;
    logic [63:0] f;
    logic [31:0] p;
    r        = $urandom_range(99);
    last_key = (entry_cnt != 0) ? key_mem[IDX_W'(entry_cnt - 1)] : 64'd0;
    p        = $urandom_range(3);
    if (r < 45) begin
      if (entry_cnt == 0) f = 64'($urandom_range(1000));
      else if ($urandom_range(99) < 40) f = last_key;
      else f = last_key + 64'($urandom_range(1, 3));
      send_item(ACT_LOAD, p, f, $urandom, 1'b0, '0);
    end else if (r < 75) begin
      if (entry_cnt == 0) f = 64'($urandom_range(1000));
      else if ($urandom_range(99) < 30 && hit_idx < entry_cnt) f = key_mem[IDX_W'(hit_idx)];
      else f = key_mem[IDX_W'($urandom_range(entry_cnt - 1))];
      send_item(ACT_QUERY, $urandom, f, $urandom, 1'b0, '0);
    end else if (r < 80) begin
      if (entry_cnt != 0 && $urandom_range(1)) begin
        f = key_mem[IDX_W'($urandom_range(entry_cnt - 1))] + 64'd1;
      end else begin
        f = {$urandom, $urandom};
      end
      send_item(ACT_QUERY, $urandom, f, $urandom, 1'b0, '0);
    end else if (r < 86) begin
      send_item(ACT_LOAD, $urandom, last_key, $urandom, 1'b0, '0);
    end else if (r < 91) begin
      send_item(ACT_LOAD, p, last_key - 64'($urandom_range(1, 5)), $urandom, 1'b0, '0);
    end else if (r < 94) begin
      send_item(ACT_LOAD, p, {$urandom, $urandom}, $urandom, 1'b0, '0);
    end else if (r < 97) begin
      send_item(ACT_UNUSED, $urandom, {$urandom, $urandom}, $urandom, 1'b0, '0);
    end else begin
      send_item(ACT_CLEAR, $urandom, {$urandom, $urandom}, $urandom, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Result side: random stall and comparison of every transfer out.
  always @(posedge clk_i) begin
    reply_t want;
    reply_t got;
    int     i;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.status = status_o;
        got.words  = {port3_value_o, port2_value_o, port1_value_o, port0_value_o};
        got.count  = present_count_o;
        replies_seen++;
        if (got.status == ST_FOUND) found_seen++;
        if (got.status == ST_FULL) full_seen++;
        if (pending_replies.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got status %0d", $time,
                   got.status);
        end else begin
          want = pending_replies.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          for (i = 0; i < NPORTS; i++) begin
            check_field($sformatf("port%0d_value", i), 64'(want.words[i]),
                        64'(got.words[i]));
          end
          check_field("present_count", 64'(want.count), 64'(got.count));
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned phase_send [4];
    int unsigned phase_recv [4];
    logic        phase_play [4];
    logic [63:0] f;
    int          n;
    int          ph;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 1'b0;
    in_valid_i     = 1'b0;
    action_i       = ACT_LOAD;
    port_i         = '0;
    frame_i        = '0;
    pad_value_i    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    transfers_in   = 0;
    replies_seen   = 0;
    found_seen     = 0;
    full_seen      = 0;
    entry_cnt      = 0;
    hit_idx        = 0;
    playback       = 1'b0;

    // Directed table: disabled playback first, then port extremes and table reuse.
    add_row(ACT_QUERY, 32'd0, 64'd0, 32'd0, 1'b1, status_reply(ST_NOTFOUND));
    add_row(ACT_LOAD, 32'd0, 64'd10, 32'hFFFF_FFFF, 1'b1, status_reply(ST_APPENDED));
    add_row(ACT_LOAD, 32'd3, 64'd10, 32'h1234_5678, 1'b1, status_reply(ST_MERGED));
    add_row(ACT_LOAD, 32'hFFFF_FFFF, 64'd10, 32'd1, 1'b1, status_reply(ST_BADPORT));
    add_row(ACT_LOAD, 32'd4, 64'd10, 32'd1, 1'b1, status_reply(ST_BADPORT));
    add_row(ACT_LOAD, 32'h8000_0000, 64'd10, 32'd1, 1'b1, status_reply(ST_BADPORT));
    add_row(ACT_LOAD, 32'h7FFF_FFFF, 64'd10, 32'd1, 1'b1, status_reply(ST_BADPORT));
    add_row(ACT_LOAD, 32'd1, 64'd9, 32'd1, 1'b1, status_reply(ST_OLDER));
    add_row(ACT_QUERY, 32'd0, 64'd10, 32'd0, 1'b1, status_reply(ST_NOTFOUND));
    add_cfg(1'b1);
    add_row(ACT_QUERY, 32'd0, 64'd10, 32'd0, 1'b1,
            '{status: ST_FOUND, words: {32'h1234_5668, 32'h0, 32'h0, 32'hFFFF_FFEF},
              count: 3'd2});
    add_row(ACT_QUERY, 32'd0, 64'd11, 32'd0, 1'b0, '0);
    add_row(ACT_LOAD, 32'd2, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, '0);
    add_row(ACT_LOAD, 32'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0010, 1'b0, '0);
    add_row(ACT_QUERY, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, '0);
    add_row(ACT_QUERY, 32'd0, 64'd10, 32'd0, 1'b0, '0);
    add_row(ACT_QUERY, 32'd0, 64'd0, 32'd0, 1'b0, '0);
    add_row(ACT_UNUSED, 32'd2, 64'd10, 32'hFFFF_FFFF, 1'b1, status_reply(ST_NOTFOUND));
    add_row(ACT_LOAD, 32'd0, 64'd0, 32'd5, 1'b1, status_reply(ST_OLDER));
    add_row(ACT_CLEAR, 32'd0, 64'd0, 32'd0, 1'b1, status_reply(ST_CLEARED));
    add_row(ACT_QUERY, 32'd0, 64'd10, 32'd0, 1'b1, status_reply(ST_NOTFOUND));
    // After a clear, stale words left in the first entry must not show up.
    add_row(ACT_LOAD, 32'd1, 64'd3, 32'hA5A5_A5A5, 1'b1, status_reply(ST_APPENDED));
    add_row(ACT_QUERY, 32'd0, 64'd3, 32'd0, 1'b0, '0);
    add_row(ACT_QUERY, 32'd0, 64'd3, 32'd0, 1'b0, '0);
    add_cfg(1'b0);
    add_row(ACT_QUERY, 32'd0, 64'd3, 32'd0, 1'b1, status_reply(ST_NOTFOUND));
    add_cfg(1'b1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[k]) begin
      if (directed_steps[k].cfg_row) begin
        set_playback(directed_steps[k].cfg_val);
      end else begin
        send_item(directed_steps[k].action, directed_steps[k].port,
                  directed_steps[k].frame, directed_steps[k].pad,
                  directed_steps[k].typed, directed_steps[k].reply);
      end
    end

    // Fill every entry, with some merges, then push past the end of the table.
    send_item(ACT_CLEAR, 32'd0, 64'd0, 32'd0, 1'b0, '0);
    f = 64'($urandom_range(100));
    for (n = 0; n < DEPTH; n++) begin
      f = f + 64'($urandom_range(1, 4));
      send_item(ACT_LOAD, $urandom_range(3), f, $urandom, 1'b0, '0);
      if ($urandom_range(3) == 0) begin
        send_item(ACT_LOAD, $urandom_range(3), f, $urandom, 1'b0, '0);
      end
    end
    send_item(ACT_LOAD, 32'd0, f + 1, $urandom, 1'b0, '0);
    send_item(ACT_LOAD, 32'd3, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, 1'b0, '0);
    send_item(ACT_LOAD, 32'd2, f, $urandom, 1'b0, '0);
    send_item(ACT_LOAD, 32'd1, f - 1, $urandom, 1'b0, '0);
    send_item(ACT_QUERY, 32'd0, key_mem[0], 32'd0, 1'b0, '0);
    send_item(ACT_QUERY, 32'd0, key_mem[DEPTH-1], 32'd0, 1'b0, '0);
    for (n = 0; n < 40; n++) begin
      f = key_mem[IDX_W'($urandom_range(DEPTH - 1))] + 64'($urandom_range(1));
      send_item(ACT_QUERY, 32'd0, f, 32'd0, 1'b0, '0);
    end

    // Random traffic under four handshake idling patterns.
    phase_send = '{0, 82, 0, 9};
    phase_recv = '{0, 0, 82, 9};
    phase_play = '{1'b1, 1'b0, 1'b1, 1'b1};
    for (ph = 0; ph < 4; ph++) begin
      set_playback(phase_play[ph]);
      send_idle_pct  = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      for (n = 0; n < 125; n++) random_item();
    end

    wait_idle();
    repeat (40) @(posedge clk_i);

    $display("Sent %0d transfers and checked %0d results (%0d found, %0d table full).",
             transfers_in, replies_seen, found_seen, full_seen);
    $display("Run covered a full table fill and random traffic with sender and receiver idling.");
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
